// File: hdl/tpe_pkg.sv
// Shared types, constants and the control store for the turtle plotter engine.
package tpe_pkg;

	localparam int BOARD_SIZE = 64;
	localparam int POS_W = $clog2(BOARD_SIZE);
	localparam int CALC_W = ((POS_W > 8) ? POS_W : 8) + 1;
	localparam int UPC_W = 4;

	localparam logic [2:0] ACT_PEN_UP = 3'd0;
	localparam logic [2:0] ACT_PEN_DOWN = 3'd1;
	localparam logic [2:0] ACT_TURN_RIGHT = 3'd2;
	localparam logic [2:0] ACT_TURN_LEFT = 3'd3;
	localparam logic [2:0] ACT_MOVE = 3'd4;
	localparam logic [2:0] ACT_READ = 3'd5;

	localparam logic [1:0] HEAD_UP = 2'd0;
	localparam logic [1:0] HEAD_RIGHT = 2'd1;
	localparam logic [1:0] HEAD_DOWN = 2'd2;
	localparam logic [1:0] HEAD_LEFT = 2'd3;

	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t PC_FETCH = 4'd0;
	localparam upc_t PC_DECODE = 4'd1;
	localparam upc_t PC_SIMPLE = 4'd2;
	localparam upc_t PC_RD_CELL = 4'd3;
	localparam upc_t PC_TAKE = 4'd4;
	localparam upc_t PC_CHECK = 4'd5;
	localparam upc_t PC_H_RD = 4'd6;
	localparam upc_t PC_H_WR = 4'd7;
	localparam upc_t PC_V_RD = 4'd8;
	localparam upc_t PC_V_LOOP = 4'd9;
	localparam upc_t PC_COMMIT = 4'd10;
	localparam upc_t PC_EMIT = 4'd11;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] step_count;
		logic [5:0] read_row;
		logic [5:0] read_col;
	} cmd_t;

	typedef struct packed {
		logic [5:0] cursor_row;
		logic [5:0] cursor_col;
		logic [1:0] heading;
		logic       pen_state;
		logic       rejected;
		logic       cell_value;
	} res_t;

	typedef enum logic [3:0] {
		UOP_FETCH,
		UOP_NOP,
		UOP_SIMPLE,
		UOP_RD_CELL,
		UOP_TAKE_CELL,
		UOP_CHECK,
		UOP_RD_ROW,
		UOP_WR_ROW,
		UOP_V_STEP,
		UOP_COMMIT,
		UOP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_GOTO,
		C_ACCEPT,
		C_DISPATCH,
		C_MOVE,
		C_LOOP,
		C_SLOT
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		upc_t  target;
	} ucode_word_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] action;
		logic       skip;
		logic       horiz;
		logic       cnt_zero;
		logic       slot_free;
	} seq_stat_t;

	typedef struct packed {
		uop_t uop;
		logic idle;
	} seq_ctrl_t;

	function automatic ucode_word_t ucode_rom(input upc_t pc);
		ucode_word_t w;
		w = '{uop: UOP_NOP, cond: C_GOTO, target: PC_FETCH};
		unique case (pc)
			PC_FETCH:   w = '{uop: UOP_FETCH,     cond: C_ACCEPT,   target: PC_DECODE};
			PC_DECODE:  w = '{uop: UOP_NOP,       cond: C_DISPATCH, target: PC_FETCH};
			PC_SIMPLE:  w = '{uop: UOP_SIMPLE,    cond: C_GOTO,     target: PC_EMIT};
			PC_RD_CELL: w = '{uop: UOP_RD_CELL,   cond: C_NEXT,     target: PC_FETCH};
			PC_TAKE:    w = '{uop: UOP_TAKE_CELL, cond: C_GOTO,     target: PC_EMIT};
			PC_CHECK:   w = '{uop: UOP_CHECK,     cond: C_MOVE,     target: PC_COMMIT};
			PC_H_RD:    w = '{uop: UOP_RD_ROW,    cond: C_NEXT,     target: PC_FETCH};
			PC_H_WR:    w = '{uop: UOP_WR_ROW,    cond: C_GOTO,     target: PC_COMMIT};
			PC_V_RD:    w = '{uop: UOP_RD_ROW,    cond: C_NEXT,     target: PC_FETCH};
			PC_V_LOOP:  w = '{uop: UOP_V_STEP,    cond: C_LOOP,     target: PC_COMMIT};
			PC_COMMIT:  w = '{uop: UOP_COMMIT,    cond: C_NEXT,     target: PC_FETCH};
			PC_EMIT:    w = '{uop: UOP_EMIT,      cond: C_SLOT,     target: PC_FETCH};
			default:    w = '{uop: UOP_NOP,       cond: C_GOTO,     target: PC_FETCH};
		endcase
		return w;
	endfunction

endpackage

// File: hdl/tpe_ram.sv
// Generic simple dual-port RAM with registered read.
module tpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/tpe_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
module tpe_sequencer import tpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output seq_ctrl_t ctrl
);

	upc_t        upc_q;
	upc_t        upc_d;
	upc_t        dispatch;
	ucode_word_t word;

	assign word = ucode_rom(upc_q);
	assign ctrl.uop = word.uop;
	assign ctrl.idle = (upc_q == PC_FETCH);

	always_comb begin
		unique case (stat.action)
			ACT_MOVE: dispatch = PC_CHECK;
			ACT_READ: dispatch = PC_RD_CELL;
			default:  dispatch = PC_SIMPLE;
		endcase
	end

	always_comb begin
		unique case (word.cond)
			C_NEXT:     upc_d = upc_q + 1'b1;
			C_GOTO:     upc_d = word.target;
			C_ACCEPT:   upc_d = stat.accepted ? word.target : upc_q;
			C_DISPATCH: upc_d = dispatch;
			C_MOVE: begin
				if (stat.skip) begin
					upc_d = word.target;
				end else begin
					upc_d = stat.horiz ? PC_H_RD : PC_V_RD;
				end
			end
			C_LOOP:     upc_d = stat.cnt_zero ? word.target : upc_q;
			C_SLOT:     upc_d = stat.slot_free ? word.target : upc_q;
			default:    upc_d = PC_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= PC_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// File: hdl/turtle_plotter_engine_unit.sv
// Turtle plotter on a BOARD_SIZE x BOARD_SIZE one-bit bitmap, run by a microcode sequencer.
// One command is taken at a time; each gives one result. A horizontal pen-down move does
// one read-modify-write of the row; a vertical pen-down move of N cells runs a marking
// loop, and the bitmap RAM writes one row per cycle. The next command can be taken in the
// same cycle that the result appears. A stalled result does not stop the next command
// from being taken, but holds back its result.
// The bitmap reads as zero after reset without a clearing pass: each row carries a
// valid flag that reset clears and the first write sets.
module turtle_plotter_engine_unit import tpe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	seq_stat_t stat;
	seq_ctrl_t ctrl;

	logic [POS_W-1:0]      row_q;
	logic [POS_W-1:0]      col_q;
	logic [1:0]            head_q;
	logic                  pen_q;
	cmd_t                  cmd_q;
	logic                  rej_q;
	logic                  cell_q;
	logic [POS_W-1:0]      tr_q;
	logic [POS_W-1:0]      tc_q;
	logic [POS_W-1:0]      walk_q;
	logic [7:0]            cnt_q;
	logic [POS_W-1:0]      rd_row_s1;
	logic                  rd_vld_s1;
	logic [BOARD_SIZE-1:0] row_vld_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic                  acc;
	logic                  slot_free;
	logic [CALC_W-1:0]     n_ext;
	logic [CALC_W-1:0]     r_ext;
	logic [CALC_W-1:0]     c_ext;
	logic [CALC_W-1:0]     tc_ext;
	logic [CALC_W-1:0]     lim;
	logic [CALC_W-1:0]     tgt_row;
	logic [CALC_W-1:0]     tgt_col;
	logic                  off_board;
	logic                  in_range;
	logic [BOARD_SIZE-1:0] hmask;
	logic [BOARD_SIZE-1:0] colbit;
	logic [BOARD_SIZE-1:0] row_old;

	logic                  ram_we;
	logic [POS_W-1:0]      ram_waddr;
	logic [BOARD_SIZE-1:0] ram_wdata;
	logic                  ram_re;
	logic [POS_W-1:0]      ram_raddr;
	logic [BOARD_SIZE-1:0] ram_rdata;

	assign cmd_stall = !ctrl.idle;
	assign acc = cmd_valid && !cmd_stall;
	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res = res_q;

	tpe_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Target check for a move
	assign n_ext = CALC_W'(cmd_q.step_count);
	assign r_ext = CALC_W'(row_q);
	assign c_ext = CALC_W'(col_q);
	assign tc_ext = CALC_W'(tc_q);
	assign lim = CALC_W'(BOARD_SIZE - 1);

	always_comb begin
		tgt_row = r_ext;
		tgt_col = c_ext;
		off_board = 1'b0;
		unique case (head_q)
			HEAD_UP: begin
				off_board = n_ext > r_ext;
				tgt_row = r_ext - n_ext;
			end
			HEAD_RIGHT: begin
				tgt_col = c_ext + n_ext;
				off_board = tgt_col > lim;
			end
			HEAD_DOWN: begin
				tgt_row = r_ext + n_ext;
				off_board = tgt_row > lim;
			end
			HEAD_LEFT: begin
				off_board = n_ext > c_ext;
				tgt_col = c_ext - n_ext;
			end
			default: ;
		endcase
	end

	assign stat.accepted = acc;
	assign stat.action = cmd_q.action;
	assign stat.skip = off_board || !pen_q || (cmd_q.step_count == 8'd0);
	assign stat.horiz = head_q[0];
	assign stat.cnt_zero = (cnt_q == 8'd0);
	assign stat.slot_free = slot_free;

	assign in_range = (CALC_W'(cmd_q.read_row) < CALC_W'(BOARD_SIZE))
		&& (CALC_W'(cmd_q.read_col) < CALC_W'(BOARD_SIZE));

	// Columns covered by a horizontal stroke: start cell in, target cell out
	always_comb begin
		for (int j = 0; j < BOARD_SIZE; j++) begin
			if (head_q == HEAD_RIGHT) begin
				hmask[j] = (CALC_W'(j) >= c_ext) && (CALC_W'(j) < tc_ext);
			end else begin
				hmask[j] = (CALC_W'(j) > tc_ext) && (CALC_W'(j) <= c_ext);
			end
		end
	end

	assign colbit = BOARD_SIZE'(1) << col_q;
	assign row_old = rd_vld_s1 ? ram_rdata : '0;

	assign ram_we = (ctrl.uop == UOP_WR_ROW) || (ctrl.uop == UOP_V_STEP);
	assign ram_waddr = rd_row_s1;
	assign ram_wdata = row_old | ((ctrl.uop == UOP_WR_ROW) ? hmask : colbit);
	assign ram_re = (ctrl.uop == UOP_RD_CELL) || (ctrl.uop == UOP_RD_ROW)
		|| ((ctrl.uop == UOP_V_STEP) && (cnt_q != 8'd0));
	assign ram_raddr = (ctrl.uop == UOP_RD_CELL) ? POS_W'(cmd_q.read_row) : walk_q;

	tpe_ram #(
		.WIDTH (BOARD_SIZE),
		.DEPTH (BOARD_SIZE)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Turtle state and per-command scratch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			head_q <= HEAD_UP;
			pen_q <= 1'b0;
			rej_q <= 1'b0;
			cell_q <= 1'b0;
			cnt_q <= '0;
			row_vld_q <= '0;
		end else begin
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			unique case (ctrl.uop)
				UOP_FETCH: begin
					if (acc) begin
						rej_q <= 1'b0;
						cell_q <= 1'b0;
					end
				end
				UOP_SIMPLE: begin
					unique case (cmd_q.action)
						ACT_PEN_UP:     pen_q <= 1'b0;
						ACT_PEN_DOWN:   pen_q <= 1'b1;
						ACT_TURN_RIGHT: head_q <= head_q + 2'd1;
						ACT_TURN_LEFT:  head_q <= head_q + 2'd3;
						default: ;
					endcase
				end
				UOP_TAKE_CELL: begin
					cell_q <= in_range && rd_vld_s1 && ram_rdata[POS_W'(cmd_q.read_col)];
				end
				UOP_CHECK: begin
					rej_q <= off_board;
					cnt_q <= cmd_q.step_count;
				end
				UOP_RD_ROW: begin
					cnt_q <= cnt_q - 8'd1;
				end
				UOP_V_STEP: begin
					if (cnt_q != 8'd0) begin
						cnt_q <= cnt_q - 8'd1;
					end
				end
				UOP_COMMIT: begin
					if (!rej_q) begin
						row_q <= tr_q;
						col_q <= tc_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload-only registers
	always_ff @(posedge clk) begin
		unique case (ctrl.uop)
			UOP_FETCH: begin
				if (acc) begin
					cmd_q <= cmd;
				end
			end
			UOP_RD_CELL: begin
				rd_vld_s1 <= row_vld_q[ram_raddr];
			end
			UOP_CHECK: begin
				tr_q <= POS_W'(tgt_row);
				tc_q <= POS_W'(tgt_col);
				walk_q <= row_q;
			end
			UOP_RD_ROW, UOP_V_STEP: begin
				if (ram_re) begin
					rd_row_s1 <= walk_q;
					rd_vld_s1 <= row_vld_q[walk_q];
					walk_q <= (head_q == HEAD_DOWN) ? walk_q + 1'b1 : walk_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((ctrl.uop == UOP_EMIT) && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.uop == UOP_EMIT) && slot_free) begin
			res_q.cursor_row <= 6'(row_q);
			res_q.cursor_col <= 6'(col_q);
			res_q.heading <= head_q;
			res_q.pen_state <= pen_q;
			res_q.rejected <= rej_q;
			res_q.cell_value <= cell_q;
		end
	end

`ifndef SYNTHESIS
	a_write_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cmd_q.action == ACT_MOVE) && pen_q && !rej_q)
		else $error("bitmap written outside a pen-down move");

	a_cursor_only_at_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uop != UOP_COMMIT) |=> $stable(row_q) && $stable(col_q))
		else $error("cursor changed outside commit step");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.rejected && res_q.cell_value))
		else $error("result both rejected and carrying a cell value");

	a_accept_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> cmd_stall && !rej_q && !cell_q)
		else $error("accepted item did not start a clean command");
`endif

endmodule
